@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define TCS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tcs assertion failed");
// When ante holds, cons must hold in the next cycle.
`define TCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcs assertion failed");
`else
`define TCS_ASSERT(lbl, clk, rst, prop)
`define TCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/tcs_pkg.sv @@
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared constants, codes and types of the character-screen controller.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int ROWS   = 10;
  localparam int COLS   = 10;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W  = 4;

  localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(ROWS - 1);
  localparam logic [IDX_W-1:0] COL_LAST = IDX_W'(COLS - 1);

  // Item kinds.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_NEW  = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_U     = 8'h75;

  // Requests from the controller to the screen memory.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              clr;
  } mem_req_t;

  // Finished result offered by the controller.
  typedef struct packed {
    logic             valid;
    logic [7:0]       cell_char;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             ins;
  } res_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    cell_addr = ADDR_W'(int'(row) * COLS + int'(col));
  endfunction

endpackage

@@ design/tcs_screen_mem.sv @@
// ----------------------------------------------------------------------------
// tcs_screen_mem
// Screen store with one write and one registered read port per cycle.
// ----------------------------------------------------------------------------
module tcs_screen_mem (
  input  logic              clk,
  input  logic              rst,
  input  tcs_pkg::mem_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0]                mem [tcs_pkg::CELLS];
  logic [tcs_pkg::CELLS-1:0] vld;
  logic [7:0]                mem_q;
  logic                      vld_q;

  // A cell never written since the last clear reads as a space.
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
      vld_q <= vld[req.rd_addr];
    end
  end

  assign rd_data = vld_q ? mem_q : tcs_pkg::CH_SPACE;

endmodule

@@ design/tcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcs_ctrl
// Escape parser, cursor state and the sequencer that walks the screen memory.
// ----------------------------------------------------------------------------
module tcs_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  output logic                      ready,
  input  logic [1:0]                kind,
  input  logic [7:0]                char_code,
  input  logic [tcs_pkg::IDX_W-1:0] read_row,
  input  logic [tcs_pkg::IDX_W-1:0] read_col,
  input  logic [7:0]                rd_data,
  output tcs_pkg::mem_req_t         mem_req,
  input  logic                      slot_free,
  output tcs_pkg::res_t             res
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_SHIFT  = 7'b0000100,
    S_PUT    = 7'b0001000,
    S_ERASE  = 7'b0010000,
    S_RDWAIT = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CARET = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  state_t                    state, state_next;
  phase_t                    phase, phase_next;
  logic [tcs_pkg::IDX_W-1:0] cur_row, cur_row_next;
  logic [tcs_pkg::IDX_W-1:0] cur_col, cur_col_next;
  logic [tcs_pkg::IDX_W-1:0] held_row, held_row_next;
  logic                      ins, ins_next;
  logic [1:0]                it_kind, it_kind_next;
  logic [7:0]                it_char, it_char_next;
  logic [tcs_pkg::IDX_W-1:0] it_rrow, it_rrow_next;
  logic [tcs_pkg::IDX_W-1:0] it_rcol, it_rcol_next;
  logic [tcs_pkg::IDX_W-1:0] idx, idx_next;
  logic [tcs_pkg::IDX_W-1:0] dst, dst_next;
  logic                      rd_on, rd_on_next;
  logic                      wr_on, wr_on_next;
  logic [7:0]                cell_byte, cell_byte_next;

  logic                      do_put;
  logic                      is_digit;
  logic [tcs_pkg::IDX_W-1:0] digit;

  assign is_digit = (it_char >= tcs_pkg::CH_ZERO) && (it_char <= tcs_pkg::CH_NINE);
  assign digit    = tcs_pkg::IDX_W'(it_char - tcs_pkg::CH_ZERO);

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    held_row_next  = held_row;
    ins_next       = ins;
    it_kind_next   = it_kind;
    it_char_next   = it_char;
    it_rrow_next   = it_rrow;
    it_rcol_next   = it_rcol;
    idx_next       = idx;
    dst_next       = dst;
    rd_on_next     = rd_on;
    wr_on_next     = wr_on;
    cell_byte_next = cell_byte;
    mem_req        = '0;
    do_put         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          it_kind_next = kind;
          it_char_next = char_code;
          it_rrow_next = read_row;
          it_rcol_next = read_col;
          state_next   = S_DECODE;
        end
      end

      S_DECODE: begin
        cell_byte_next = '0;
        state_next     = S_DONE;
        unique case (it_kind)
          tcs_pkg::KIND_BYTE: begin
            unique case (phase)
              PH_IDLE: begin
                if (it_char == tcs_pkg::CH_CARET) begin
                  phase_next = PH_CARET;
                end else begin
                  do_put = 1'b1;
                end
              end
              PH_CARET: begin
                phase_next = PH_IDLE;
                unique case (it_char)
                  tcs_pkg::CH_B: cur_col_next = '0;
                  tcs_pkg::CH_C: mem_req.clr = 1'b1;
                  tcs_pkg::CH_D: begin
                    if (cur_row < tcs_pkg::ROW_LAST) cur_row_next = cur_row + 1'b1;
                  end
                  tcs_pkg::CH_U: begin
                    if (cur_row != '0) cur_row_next = cur_row - 1'b1;
                  end
                  tcs_pkg::CH_L: begin
                    if (cur_col != '0) cur_col_next = cur_col - 1'b1;
                  end
                  tcs_pkg::CH_R: begin
                    if (cur_col < tcs_pkg::COL_LAST) cur_col_next = cur_col + 1'b1;
                  end
                  tcs_pkg::CH_E: begin
                    idx_next   = cur_col;
                    state_next = S_ERASE;
                  end
                  tcs_pkg::CH_H: begin
                    cur_row_next = '0;
                    cur_col_next = '0;
                  end
                  tcs_pkg::CH_I: ins_next = 1'b1;
                  tcs_pkg::CH_O: ins_next = 1'b0;
                  tcs_pkg::CH_CARET: do_put = 1'b1;
                  default: begin
                    // Unknown letters are dropped; a digit opens a position escape.
                    if (is_digit) begin
                      held_row_next = digit;
                      phase_next    = PH_DIGIT;
                    end
                  end
                endcase
              end
              PH_DIGIT: begin
                phase_next = PH_IDLE;
                if (is_digit) begin
                  cur_row_next = (held_row < tcs_pkg::ROWS) ? held_row : tcs_pkg::ROW_LAST;
                  cur_col_next = (digit < tcs_pkg::COLS) ? digit : tcs_pkg::COL_LAST;
                end
              end
              default: phase_next = PH_IDLE;
            endcase
          end
          tcs_pkg::KIND_READ: begin
            if ((it_rrow < tcs_pkg::ROWS) && (it_rcol < tcs_pkg::COLS)) begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = tcs_pkg::cell_addr(it_rrow, it_rcol);
              state_next      = S_RDWAIT;
            end
          end
          tcs_pkg::KIND_NEW: begin
            mem_req.clr   = 1'b1;
            cur_row_next  = '0;
            cur_col_next  = '0;
            ins_next      = 1'b0;
            phase_next    = PH_IDLE;
            held_row_next = '0;
          end
          default: ;
        endcase

        if (do_put) begin
          if (ins && (cur_col < tcs_pkg::COL_LAST)) begin
            // Walk the row from the right end, one source cell per cycle.
            idx_next   = tcs_pkg::COL_LAST - 1'b1;
            rd_on_next = 1'b1;
            wr_on_next = 1'b0;
            state_next = S_SHIFT;
          end else begin
            state_next = S_PUT;
          end
        end
      end

      S_SHIFT: begin
        // The read of one cell overlaps the write-back of the cell read before it.
        if (wr_on) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = tcs_pkg::cell_addr(cur_row, dst);
          mem_req.wr_data = rd_data;
        end
        if (rd_on) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = tcs_pkg::cell_addr(cur_row, idx);
          dst_next        = idx + 1'b1;
          wr_on_next      = 1'b1;
          if (idx == cur_col) begin
            rd_on_next = 1'b0;
          end else begin
            idx_next = idx - 1'b1;
          end
        end else begin
          wr_on_next = 1'b0;
          state_next = S_PUT;
        end
      end

      S_PUT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = tcs_pkg::cell_addr(cur_row, cur_col);
        mem_req.wr_data = it_char;
        if (cur_col < tcs_pkg::COL_LAST) cur_col_next = cur_col + 1'b1;
        state_next = S_DONE;
      end

      S_ERASE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = tcs_pkg::cell_addr(cur_row, idx);
        mem_req.wr_data = tcs_pkg::CH_SPACE;
        idx_next        = idx + 1'b1;
        if (idx >= tcs_pkg::COL_LAST) state_next = S_DONE;
      end

      S_RDWAIT: begin
        cell_byte_next = rd_data;
        state_next     = S_DONE;
      end

      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_IDLE;
      cur_row  <= '0;
      cur_col  <= '0;
      held_row <= '0;
      ins      <= 1'b0;
      rd_on    <= 1'b0;
      wr_on    <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      held_row <= held_row_next;
      ins      <= ins_next;
      rd_on    <= rd_on_next;
      wr_on    <= wr_on_next;
    end
  end

  always_ff @(posedge clk) begin
    it_kind   <= it_kind_next;
    it_char   <= it_char_next;
    it_rrow   <= it_rrow_next;
    it_rcol   <= it_rcol_next;
    idx       <= idx_next;
    dst       <= dst_next;
    cell_byte <= cell_byte_next;
  end

  assign ready         = (state == S_IDLE);
  assign res.valid     = (state == S_DONE);
  assign res.cell_char = cell_byte;
  assign res.row       = cur_row;
  assign res.col       = cur_col;
  assign res.ins       = ins;

endmodule

@@ design/terminal_control_sequence_screen.sv @@
// ----------------------------------------------------------------------------
// terminal_control_sequence_screen
// Character-screen controller driven by a byte stream with caret escapes.
// ----------------------------------------------------------------------------
// Each input word is a stream byte, a read of one screen cell, or a request to
// start a new screen, and each one yields exactly one output word with the
// cell read (zero for other kinds or a read off the screen), the cursor after
// the word and the insert-mode flag. The screen lives in a 100-cell memory
// with one write port and one registered read port; a flip-flop valid bit per
// cell lets a clear or a new screen blank every cell at once, so there is
// no clearing pass after reset. Cost per word is set by that memory port:
// cursor moves, mode changes and escape prefixes go from decode straight to
// the output word, reads wait for the registered read and overwrites add a
// write step; an erase to end of line writes the erased cells one by one; an
// inserted character first shifts the row tail right one cell per cycle, the
// read of the next cell overlapping the write-back of the previous one. A new
// input word is taken in the cycle after the output word is loaded, as soon
// as the controller is idle, even while the previous output word still waits
// in the output register.
module terminal_control_sequence_screen (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                kind,
  input  logic [7:0]                char_code,
  input  logic [tcs_pkg::IDX_W-1:0] read_row,
  input  logic [tcs_pkg::IDX_W-1:0] read_col,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                cell_char,
  output logic [tcs_pkg::IDX_W-1:0] cursor_row_now,
  output logic [tcs_pkg::IDX_W-1:0] cursor_col_now,
  output logic                      insert_on
);

`include "assert_macros.svh"

  tcs_pkg::mem_req_t mem_req;
  tcs_pkg::res_t     res;
  logic [7:0]        rd_data;
  logic              accept;
  logic              slot_free;
  logic              cursor_on_screen;

  assign accept    = in_valid && in_ready;
  // The output register can take a new word when empty or being drained.
  assign slot_free = !out_valid || out_ready;

  tcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .ready     (in_ready),
    .kind      (kind),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .slot_free (slot_free),
    .res       (res)
  );

  tcs_screen_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Output register: parts the controller from the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && slot_free) begin
      cell_char      <= res.cell_char;
      cursor_row_now <= res.row;
      cursor_col_now <= res.col;
      insert_on      <= res.ins;
    end
  end

  assign cursor_on_screen = (cursor_row_now < tcs_pkg::ROWS) &&
                            (cursor_col_now < tcs_pkg::COLS);

  // The cursor reported with every word stays on the screen.
  `TCS_ASSERT(a_cursor_on_screen, clk, rst, !out_valid || cursor_on_screen)
  // Once a word is taken the controller is busy until its result is built.
  `TCS_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !in_ready)
  // A finished result is held until the output register takes it.
  `TCS_ASSERT_NEXT(a_result_held, clk, rst, res.valid && !slot_free, res.valid)

endmodule

@@ test/terminal_control_sequence_screen_test.sv @@
// ----------------------------------------------------------------------------
// terminal_control_sequence_screen_test
// Self-checking bench for the character-screen controller: it sends stream
// bytes, cell reads and new-screen requests, predicts every output word from
// its own model of the screen, cursor, insert flag and escape parser, and
// compares each output word field by field under several idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module terminal_control_sequence_screen_test;

  // The kind code that the block must treat as a no-operation.
  localparam logic [1:0] KIND_NONE = 2'd3;
  // A letter that is not a known escape command.
  localparam logic [7:0] CH_Z = 8'h7A;
  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_CARET,
    ESC_DIGIT
  } esc_phase_t;

  // One output word as the block should present it.
  typedef struct packed {
    logic [7:0]                cell_byte;
    logic [tcs_pkg::IDX_W-1:0] row;
    logic [tcs_pkg::IDX_W-1:0] col;
    logic                      ins;
  } screen_word_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                kind = tcs_pkg::KIND_BYTE;
  logic [7:0]                char_code = 8'h00;
  logic [tcs_pkg::IDX_W-1:0] read_row = '0;
  logic [tcs_pkg::IDX_W-1:0] read_col = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [7:0]                cell_char;
  logic [tcs_pkg::IDX_W-1:0] cursor_row_now;
  logic [tcs_pkg::IDX_W-1:0] cursor_col_now;
  logic                      insert_on;

  // Screen model: store, cursor, insert flag and escape parser.
  logic [7:0]                model_screen [tcs_pkg::ROWS][tcs_pkg::COLS];
  logic [tcs_pkg::IDX_W-1:0] model_row;
  logic [tcs_pkg::IDX_W-1:0] model_col;
  logic [tcs_pkg::IDX_W-1:0] model_held;
  logic                      model_insert;
  esc_phase_t                model_phase;

  // Words whose output has been predicted but not yet seen, oldest first.
  screen_word_t pending_words[$];

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int gap_pct = 0;
  int stall_pct = 0;

  int mismatches = 0;
  int words_sent = 0;
  int results_checked = 0;
  int reads_sent = 0;
  int escapes_seen = 0;
  int inserts_seen = 0;
  int quiet_cycles = 0;

  terminal_control_sequence_screen i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cell_char      (cell_char),
    .cursor_row_now (cursor_row_now),
    .cursor_col_now (cursor_col_now),
    .insert_on      (insert_on)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Screen model
  // ---------------------------------------------------------------------------

  task automatic blank_model_screen();
    foreach (model_screen[r, c]) begin
      model_screen[r][c] = tcs_pkg::CH_SPACE;
    end
  endtask

  // A new screen and the power-on state are the same thing.
  task automatic reset_model();
    blank_model_screen();
    model_row = '0;
    model_col = '0;
    model_held = '0;
    model_insert = 1'b0;
    model_phase = ESC_IDLE;
  endtask

  // Writes a character at the cursor. In insert mode the rest of the row moves
  // one cell to the right first and the last cell falls off. The cursor then
  // advances but sticks at the last column.
  task automatic place_glyph(input logic [7:0] ch);
    if (model_insert) begin
      inserts_seen++;
      for (int j = tcs_pkg::COLS - 1; j > model_col; j--) begin
        model_screen[model_row][j] = model_screen[model_row][j-1];
      end
    end
    model_screen[model_row][model_col] = ch;
    if (model_col < tcs_pkg::COL_LAST) begin
      model_col++;
    end
  endtask

  // The byte that follows a caret. Any letter that is not a command simply
  // ends the escape; a digit starts a cursor-position escape.
  task automatic apply_escape(input logic [7:0] ch);
    escapes_seen++;
    model_phase = ESC_IDLE;
    case (ch)
      tcs_pkg::CH_B: model_col = '0;
      tcs_pkg::CH_C: blank_model_screen();
      tcs_pkg::CH_D: begin
        if (model_row < tcs_pkg::ROW_LAST) model_row++;
      end
      tcs_pkg::CH_U: begin
        if (model_row > 0) model_row--;
      end
      tcs_pkg::CH_L: begin
        if (model_col > 0) model_col--;
      end
      tcs_pkg::CH_R: begin
        if (model_col < tcs_pkg::COL_LAST) model_col++;
      end
      tcs_pkg::CH_E: begin
        for (int j = model_col; j < tcs_pkg::COLS; j++) begin
          model_screen[model_row][j] = tcs_pkg::CH_SPACE;
        end
      end
      tcs_pkg::CH_H: begin
        model_row = '0;
        model_col = '0;
      end
      tcs_pkg::CH_I: model_insert = 1'b1;
      tcs_pkg::CH_O: model_insert = 1'b0;
      tcs_pkg::CH_CARET: place_glyph(ch);
      default: begin
        if (ch >= tcs_pkg::CH_ZERO && ch <= tcs_pkg::CH_NINE) begin
          model_held = tcs_pkg::IDX_W'(ch - tcs_pkg::CH_ZERO);
          model_phase = ESC_DIGIT;
        end
      end
    endcase
  endtask

  task automatic apply_stream_byte(input logic [7:0] ch);
    logic [tcs_pkg::IDX_W-1:0] new_col;
    case (model_phase)
      ESC_CARET: apply_escape(ch);
      ESC_DIGIT: begin
        // The second digit completes the position; anything else drops the
        // whole escape together with the offending byte.
        model_phase = ESC_IDLE;
        if (ch >= tcs_pkg::CH_ZERO && ch <= tcs_pkg::CH_NINE) begin
          new_col = tcs_pkg::IDX_W'(ch - tcs_pkg::CH_ZERO);
          model_row = (model_held < tcs_pkg::ROWS) ? model_held : tcs_pkg::ROW_LAST;
          model_col = (new_col < tcs_pkg::COLS) ? new_col : tcs_pkg::COL_LAST;
        end
      end
      default: begin
        if (ch == tcs_pkg::CH_CARET) begin
          model_phase = ESC_CARET;
        end else begin
          place_glyph(ch);
        end
      end
    endcase
  endtask

  // Advances the model by one accepted word and returns its output word.
  task automatic predict_word(input logic [1:0] word_kind, input logic [7:0] byte_val,
                              input logic [tcs_pkg::IDX_W-1:0] row_sel,
                              input logic [tcs_pkg::IDX_W-1:0] col_sel,
                              output screen_word_t want);
    want.cell_byte = 8'h00;
    case (word_kind)
      tcs_pkg::KIND_BYTE: apply_stream_byte(byte_val);
      tcs_pkg::KIND_READ: begin
        // A read off the screen returns zero; a read never touches the parser.
        if (row_sel < tcs_pkg::ROWS && col_sel < tcs_pkg::COLS) begin
          want.cell_byte = model_screen[row_sel][col_sel];
        end
      end
      tcs_pkg::KIND_NEW: reset_model();
      default: ;
    endcase
    want.row = model_row;
    want.col = model_col;
    want.ins = model_insert;
  endtask

  // ---------------------------------------------------------------------------
  // Sending side
  // ---------------------------------------------------------------------------

  // Presents one word and holds it until the block takes it. The payload only
  // changes on a falling edge, and the first falling edge after an acceptance
  // either lowers valid or carries the next word, so valid is never dropped
  // and raised again in the same step.
  task automatic send_word(input logic [1:0] word_kind, input logic [7:0] byte_val,
                           input logic [tcs_pkg::IDX_W-1:0] row_sel,
                           input logic [tcs_pkg::IDX_W-1:0] col_sel);
    screen_word_t want;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    kind      <= word_kind;
    char_code <= byte_val;
    read_row  <= row_sel;
    read_col  <= col_sel;
    do @(posedge clk); while (!in_ready);
    predict_word(word_kind, byte_val, row_sel, col_sel, want);
    pending_words.push_back(want);
    words_sent++;
    if (word_kind == tcs_pkg::KIND_READ) reads_sent++;
  endtask

  // Stream byte; the unused read coordinates carry random bits.
  task automatic send_byte(input logic [7:0] ch);
    send_word(tcs_pkg::KIND_BYTE, ch, tcs_pkg::IDX_W'($urandom_range(15)),
              tcs_pkg::IDX_W'($urandom_range(15)));
  endtask

  task automatic send_escape(input logic [7:0] letter);
    send_byte(tcs_pkg::CH_CARET);
    send_byte(letter);
  endtask

  task automatic read_cell(input int row_sel, input int col_sel);
    send_word(tcs_pkg::KIND_READ, 8'($urandom_range(255)), tcs_pkg::IDX_W'(row_sel),
              tcs_pkg::IDX_W'(col_sel));
  endtask

  // Kinds other than a byte or a read, with random don't-care fields.
  task automatic send_control(input logic [1:0] word_kind);
    send_word(word_kind, 8'($urandom_range(255)), tcs_pkg::IDX_W'($urandom_range(15)),
              tcs_pkg::IDX_W'($urandom_range(15)));
  endtask

  // Stops sending until every predicted word has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiving side and checking
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Every accepted output word is matched against the oldest prediction.
  always @(posedge clk) begin
    screen_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("output word arrived with nothing expected");
      end else begin
        want = pending_words.pop_front();
        if (cell_char !== want.cell_byte) begin
          report_mismatch($sformatf("word %0d: cell_char %02h, expected %02h",
                                    results_checked, cell_char, want.cell_byte));
        end
        if (cursor_row_now !== want.row) begin
          report_mismatch($sformatf("word %0d: cursor_row_now %0d, expected %0d",
                                    results_checked, cursor_row_now, want.row));
        end
        if (cursor_col_now !== want.col) begin
          report_mismatch($sformatf("word %0d: cursor_col_now %0d, expected %0d",
                                    results_checked, cursor_col_now, want.col));
        end
        if (insert_on !== want.ins) begin
          report_mismatch($sformatf("word %0d: insert_on %0b, expected %0b",
                                    results_checked, insert_on, want.ins));
        end
        results_checked++;
      end
    end
  end

  // Any handshake on either side shows progress; a long silence means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every escape command once, plus text at the byte extremes.
  task automatic test_escape_commands();
    send_byte(8'h41);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_escape(tcs_pkg::CH_B);
    // Insert at column 0 pushes the three characters to the right.
    send_escape(tcs_pkg::CH_I);
    send_byte(8'h5A);
    read_cell(0, 3);
    send_escape(tcs_pkg::CH_O);
    send_escape(tcs_pkg::CH_R);
    send_escape(tcs_pkg::CH_E);
    send_escape(tcs_pkg::CH_D);
    send_escape(tcs_pkg::CH_L);
    send_escape(tcs_pkg::CH_U);
    // A doubled caret is an ordinary character.
    send_escape(tcs_pkg::CH_CARET);
    // Bottom-right corner, then a write there leaves the cursor in place.
    send_byte(tcs_pkg::CH_CARET);
    send_byte(tcs_pkg::CH_NINE);
    send_byte(tcs_pkg::CH_NINE);
    send_byte(8'h7E);
    read_cell(9, 9);
    send_escape(tcs_pkg::CH_H);
    send_escape(tcs_pkg::CH_C);
    read_cell(0, 0);
    wait_for_results();
  endtask

  task automatic test_special_cases();
    // An unknown letter after a caret is dropped.
    send_escape(CH_Z);
    // A non-digit after caret and digit drops the escape and the byte.
    send_byte(tcs_pkg::CH_CARET);
    send_byte(tcs_pkg::CH_ZERO + 8'd5);
    send_byte(CH_Z);
    // A read in the middle of an escape leaves the parser where it was.
    send_byte(tcs_pkg::CH_CARET);
    read_cell(0, 0);
    send_byte(tcs_pkg::CH_ZERO + 8'd3);
    send_byte(tcs_pkg::CH_ZERO + 8'd4);
    // A new screen abandons a half-done escape.
    send_byte(tcs_pkg::CH_CARET);
    send_control(tcs_pkg::KIND_NEW);
    send_byte(8'h51);
    // The spare kind does nothing.
    send_control(KIND_NONE);
    // Reads outside the screen return zero.
    read_cell(15, 15);
    read_cell(10, 0);
    read_cell(0, 10);
    wait_for_results();
  endtask

  // Mostly well-formed escapes and text with random content, plenty of reads,
  // and a minority of broken escapes, new screens and the spare kind.
  task automatic test_random_traffic(input int word_count, input int sender_gap,
                                     input int receiver_stall);
    logic [7:0] commands [11];
    int first;
    int pick;
    commands = '{tcs_pkg::CH_B, tcs_pkg::CH_D, tcs_pkg::CH_U, tcs_pkg::CH_L,
                 tcs_pkg::CH_R, tcs_pkg::CH_E, tcs_pkg::CH_H, tcs_pkg::CH_I,
                 tcs_pkg::CH_O, tcs_pkg::CH_CARET, tcs_pkg::CH_C};
    first = words_sent;
    gap_pct = sender_gap;
    stall_pct = receiver_stall;
    while (words_sent - first < word_count) begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        send_byte(8'($urandom_range(255)));
      end else if (pick < 58) begin
        send_escape(commands[$urandom_range(10)]);
      end else if (pick < 70) begin
        send_byte(tcs_pkg::CH_CARET);
        send_byte(tcs_pkg::CH_ZERO + 8'($urandom_range(9)));
        send_byte(tcs_pkg::CH_ZERO + 8'($urandom_range(9)));
      end else if (pick < 88) begin
        // Mostly on the screen, now and then anywhere the field allows.
        if ($urandom_range(7) == 0) begin
          read_cell($urandom_range(15), $urandom_range(15));
        end else begin
          read_cell($urandom_range(9), $urandom_range(9));
        end
      end else if (pick < 92) begin
        send_byte(tcs_pkg::CH_CARET);
        send_byte(8'($urandom_range(255)));
      end else if (pick < 95) begin
        send_byte(tcs_pkg::CH_CARET);
        send_byte(tcs_pkg::CH_ZERO + 8'($urandom_range(9)));
        send_byte(8'($urandom_range(255)));
      end else if (pick < 97) begin
        send_control(tcs_pkg::KIND_NEW);
      end else begin
        send_control(KIND_NONE);
      end
    end
    wait_for_results();
    gap_pct = 0;
    stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_escape_commands();
    test_special_cases();
    // Random phases: free flow, idle sender, stalling receiver, then both.
    test_random_traffic(120, 0, 0);
    test_random_traffic(160, 53, 0);
    test_random_traffic(160, 0, 53);
    test_random_traffic(160, 16, 16);

    // Let any stray output word show up before the verdict.
    repeat (40) @(posedge clk);
    if (pending_words.size() != 0) begin
      report_mismatch($sformatf("%0d output words never arrived", pending_words.size()));
    end

    $display("Run covered %0d words (%0d reads, %0d escapes, %0d inserted characters),",
             words_sent, reads_sent, escapes_seen, inserts_seen);
    $display("with %0d output words checked under four idling patterns.", results_checked);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
